>>> hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants, types and helpers of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic        [LEN_W-1:0]  len_t;

    localparam len_t LEN_MAX = len_t'(WINDOW_MAX);
    localparam len_t LEN_ONE = len_t'(1);

    // what a cell shows to its neighbors
    typedef struct packed {
        logic  valid;
        logic  keep;
        data_t value;
        len_t  age;
    } cell_state_t;

    // broadcast to every cell of one chain
    typedef struct packed {
        logic  accept;
        logic  shift;
        logic  clear;
        data_t sample;
    } cell_ctrl_t;

    // one accepted sample, top to deque
    typedef struct packed {
        logic  accept;
        logic  last;
        data_t sample;
    } swmm_step_t;

    // zero reads as one, anything above the depth saturates
    function automatic len_t clamp_len(input len_t raw);
        len_t res;
        res = raw;
        if (raw == '0)
        begin
            res = LEN_ONE;
        end
        else if (raw > LEN_MAX)
        begin
            res = LEN_MAX;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/swmm_ifs.sv
// ----------------------------------------------------------------------------
// swmm_ifs
// Valid/ready channels of the sliding window min/max block.
// ----------------------------------------------------------------------------
interface swmm_in_if;
    logic                  valid;
    logic                  ready;
    swmm_pkg::data_t       sample;
    logic                  last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface swmm_out_if;
    logic                  valid;
    logic                  ready;
    swmm_pkg::data_t       window_min;
    swmm_pkg::data_t       window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

interface swmm_cfg_if;
    logic                  valid;
    logic                  ready;
    swmm_pkg::len_t        window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

>>> hw/rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Minimum and maximum of the last window_len signed samples, two cell-chain
// monotonic deques.
// ----------------------------------------------------------------------------
//  channel   dir   word                       handshake
//  samples   in    sample, last_in            valid/ready
//  results   out   window_min, window_max     valid/ready
//  cfg       in    window_len                 valid/ready (always ready)
//
//  one cycle per sample unless a chain is busy or the output is stalled:
//  every cell of both chains expires, pops and pushes in the same edge.
//  after window_len is made shorter, each extra entry that has fallen out
//  of the window is dropped before the next sample. results sit in an
//  output register; a new sample is taken while it drains. reset clears the
//  cell valid bits at once, no clearing pass.
module sliding_window_min_max (
    input  logic         clk,
    input  logic         rst_n,
    swmm_in_if.sink      samples,
    swmm_out_if.source   results,
    swmm_cfg_if.sink     cfg
);

    // window length, held already clamped
    swmm_pkg::len_t  len_reg, len_next;

    // samples seen this sequence, saturating at the depth
    swmm_pkg::len_t  fill_reg, fill_next;
    logic            full_reg, full_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    swmm_pkg::data_t out_min_reg, out_min_next;
    swmm_pkg::data_t out_max_reg, out_max_next;

    swmm_pkg::swmm_step_t step;
    logic            accept;
    logic            produce;
    logic            busy_min, busy_max;
    swmm_pkg::data_t head_min, head_max;

    // ready only when both chains have at most one stale head entry and the output register is empty or being read
    assign samples.ready = !busy_min && !busy_max && (!out_valid_reg || results.ready);
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    assign step = '{accept: accept, last: samples.last_in, sample: samples.sample};

    swmm_deque u_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .len       (len_reg),
        .want_max  (1'b0),
        .busy      (busy_min),
        .head_next (head_min)
    );

    swmm_deque u_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .len       (len_reg),
        .want_max  (1'b1),
        .busy      (busy_max),
        .head_next (head_max)
    );

    // window counts as full once len samples are in; sticky until last
    assign produce = full_reg || ((fill_reg + swmm_pkg::LEN_ONE) >= len_reg);

    always_comb
    begin
        len_next = len_reg;
        if (cfg.valid && cfg.ready)
        begin
            len_next = swmm_pkg::clamp_len(cfg.window_len);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        full_next = full_reg;
        if (accept)
        begin
            if (samples.last_in)
            begin
                fill_next = '0;
                full_next = 1'b0;
            end
            else
            begin
                full_next = produce;
                if (fill_reg != swmm_pkg::LEN_MAX)
                begin
                    fill_next = fill_reg + swmm_pkg::LEN_ONE;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        if (accept && produce)
        begin
            out_valid_next = 1'b1;
            out_min_next   = head_min;
            out_max_next   = head_max;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= swmm_pkg::LEN_ONE;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.window_min = out_min_reg;
    assign results.window_max = out_max_reg;

`ifndef NO_ASSERTIONS
    // both chains see the same window, so the heads can never cross
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_min_reg <= out_max_reg))
        else $error("window_min above window_max");

    // a last sample restarts the sequence count
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.last_in) |=> (fill_reg == '0) && !full_reg)
        else $error("sequence state not cleared after last word");

    // a full window always leaves a word in the output register
    a_produce_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce) |=> out_valid_reg)
        else $error("result word lost");

    // no sample enters while a chain still holds stale entries
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_min || busy_max) |-> !accept)
        else $error("sample taken while dropping stale entries");
`endif

endmodule

>>> hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One deque slot: value, age and occupancy; shifts toward the head on demand.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swmm_pkg::cell_ctrl_t   ctrl,
    input  logic                   want_max,
    input  swmm_pkg::cell_state_t  right,
    input  logic                   left_occ,
    output swmm_pkg::cell_state_t  state,
    output logic                   occ
);

    logic            valid_reg, valid_next;
    swmm_pkg::data_t value_reg, value_next;
    swmm_pkg::len_t  age_reg, age_next;

    logic            dom;
    logic            keep;
    logic            src_keep;
    logic            load;
    swmm_pkg::data_t src_value;
    swmm_pkg::len_t  src_age;

    always_comb
    begin
        if (want_max)
        begin
            dom = ctrl.accept && (value_reg <= ctrl.sample);
        end
        else
        begin
            dom = ctrl.accept && (value_reg >= ctrl.sample);
        end
        keep = valid_reg && !dom;

        // head-ward shift takes the neighbor's surviving entry
        src_keep  = ctrl.shift ? right.keep  : keep;
        src_value = ctrl.shift ? right.value : value_reg;
        src_age   = ctrl.shift ? right.age   : age_reg;

        // new word lands in the first free slot after the survivors
        load = ctrl.accept && !src_keep && left_occ;

        valid_next = !ctrl.clear && (src_keep || load);
        value_next = load ? ctrl.sample : src_value;
        if (load)
        begin
            age_next = swmm_pkg::LEN_ONE;
        end
        else if (ctrl.accept)
        begin
            age_next = src_age + swmm_pkg::LEN_ONE;
        end
        else
        begin
            age_next = src_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign state = '{valid: valid_reg, keep: keep, value: value_reg, age: age_reg};
    assign occ   = src_keep;

endmodule

>>> hw/rtl/swmm_deque.sv
// ----------------------------------------------------------------------------
// swmm_deque
// Monotonic deque as a row of cells, head in cell 0.
// ----------------------------------------------------------------------------
module swmm_deque (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swmm_pkg::swmm_step_t  step,
    input  swmm_pkg::len_t        len,
    input  logic                  want_max,
    output logic                  busy,
    output swmm_pkg::data_t       head_next
);

    swmm_pkg::cell_state_t cs  [swmm_pkg::WINDOW_MAX];
    logic                  occ [swmm_pkg::WINDOW_MAX];
    swmm_pkg::cell_ctrl_t  ctrl;
    logic                  head_exp;

    localparam swmm_pkg::cell_state_t EMPTY_CELL = '0;

    // more than one expired entry at the head: drop one per cycle first
    assign head_exp = cs[0].valid && (cs[0].age >= len);
    assign busy     = cs[1].valid && (cs[1].age >= len);

    always_comb
    begin
        ctrl.accept = step.accept;
        ctrl.shift  = busy || (step.accept && head_exp);
        ctrl.clear  = step.accept && step.last;
        ctrl.sample = step.sample;

        if (ctrl.shift ? cs[1].keep : cs[0].keep)
        begin
            head_next = ctrl.shift ? cs[1].value : cs[0].value;
        end
        else
        begin
            head_next = step.sample;
        end
    end

    for (genvar i = 0; i < swmm_pkg::WINDOW_MAX; i++)
    begin : g_cell
        swmm_pkg::cell_state_t right_s;
        logic                  left_o;

        if (i == swmm_pkg::WINDOW_MAX - 1)
        begin : g_tail
            assign right_s = EMPTY_CELL;
        end
        else
        begin : g_mid
            assign right_s = cs[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_o = 1'b1;
        end
        else
        begin : g_body
            assign left_o = occ[i-1];
        end

        swmm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .want_max (want_max),
            .right    (right_s),
            .left_occ (left_o),
            .state    (cs[i]),
            .occ      (occ[i])
        );
    end

endmodule

>>> test/tb_sliding_window_min_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max
// Streams signed samples into the sliding window min/max block and checks
// every window_min/window_max word against a deque-based predictor. A short
// directed table runs first, then random sequences over many window lengths,
// ending with one long sequence at the full window depth.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max;

    // settle time before a window_len write, after the last word came back
    localparam int SETTLE_CYCLES = 4;
    // tail wait once every expected word has arrived
    localparam int DRAIN_CYCLES  = 16;
    // cycles without any handshake before the run is called hung; the worst
    // legitimate stall is the expiry of a full deque after a shortened window
    localparam int QUIET_LIMIT   = 5000;
    // random samples per idling regime for the short-window sequences
    localparam int REGIME_ITEMS  = 375;

    localparam swmm_pkg::data_t SAMPLE_MIN  = swmm_pkg::data_t'(32'h8000_0000);
    localparam swmm_pkg::data_t SAMPLE_MAX  = swmm_pkg::data_t'(32'h7FFF_FFFF);
    localparam swmm_pkg::data_t SAMPLE_ZERO = swmm_pkg::data_t'(0);
    localparam swmm_pkg::data_t SAMPLE_NEG1 = swmm_pkg::data_t'(-1);
    localparam swmm_pkg::data_t SAMPLE_FIVE = swmm_pkg::data_t'(5);
    localparam swmm_pkg::data_t SAMPLE_ALT  = swmm_pkg::data_t'(32'hAAAA_AAAA);
    localparam swmm_pkg::len_t  LEN_ZERO    = swmm_pkg::len_t'(0);
    localparam swmm_pkg::len_t  LEN_RAW_TOP = swmm_pkg::len_t'(2047);

    typedef enum logic { ROW_SAMPLE, ROW_CFG } row_kind_e;

    // how the values of one run of samples are shaped
    typedef enum int { SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISE, SHAPE_FALL,
                       SHAPE_EDGES } shape_e;

    typedef struct packed {
        row_kind_e       kind;
        logic [31:0]     word;   // sample, or window_len for a cfg row
        logic            last;
        logic            typed;  // expected word given below instead of predicted
        swmm_pkg::data_t lo;
        swmm_pkg::data_t hi;
    } plan_row_t;

    typedef struct {
        swmm_pkg::data_t value;
        logic [31:0]     pos;
    } deque_entry_t;

    typedef struct packed {
        swmm_pkg::data_t lo;
        swmm_pkg::data_t hi;
    } window_pair_t;

    logic clk;
    logic rst_n;

    swmm_in_if  samples ();
    swmm_out_if results ();
    swmm_cfg_if cfg ();

    sliding_window_min_max u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // predictor state: own copy of window_len, both deques, position counter
    // ------------------------------------------------------------------------
    swmm_pkg::len_t win_len_reg;
    deque_entry_t   lo_deque [$];   // increasing values, head is the minimum
    deque_entry_t   hi_deque [$];   // decreasing values, head is the maximum
    logic [31:0]    sample_pos;
    bit             win_full;

    window_pair_t pending_windows [$];
    window_pair_t arrived_want;

    int              err_count;
    int              samples_sent;
    int              quiet_cycles;
    int              src_idle_pct;
    int              snk_idle_pct;
    swmm_pkg::data_t ramp_val;

    // directed table: extremes at window 1, zero and saturated lengths,
    // equal values, single-sample sequence that never fills its window
    plan_row_t directed_plan [22] = '{
        // window 1 after reset: every word is the sample itself
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MAX},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MIN},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1, SAMPLE_NEG1, SAMPLE_NEG1},
        // zero length reads as one
        '{ROW_CFG,    32'd0,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd5,         1'b0, 1'b1, SAMPLE_FIVE, SAMPLE_FIVE},
        '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 1'b1, SAMPLE_ALT, SAMPLE_ALT},
        // window 3, both extremes inside it
        '{ROW_CFG,    32'd3,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd10,        1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
        '{ROW_SAMPLE, 32'd7,         1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
        '{ROW_SAMPLE, 32'd7,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd7,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        // window 2: a lone last sample gives nothing, then a short pair
        '{ROW_CFG,    32'd2,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b1, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd4,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd4,         1'b1, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        // all-ones length saturates to the full depth: no word for these
        '{ROW_CFG,    32'd2047,      1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO},
        '{ROW_SAMPLE, 32'd2,         1'b1, 1'b0, SAMPLE_ZERO, SAMPLE_ZERO}
    };

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // zero acts as one, anything past the depth saturates
    function automatic int unsigned effective_len();
        if (win_len_reg == LEN_ZERO)
        begin
            return 1;
        end
        if (win_len_reg > swmm_pkg::len_t'(swmm_pkg::WINDOW_MAX))
        begin
            return swmm_pkg::WINDOW_MAX;
        end
        return int'(win_len_reg);
    endfunction

    function automatic void clear_windows();
        lo_deque.delete();
        hi_deque.delete();
        sample_pos = '0;
        win_full   = 1'b0;
    endfunction

    // one sample through both deques; returns 1 when a word is due
    function automatic bit slide_window(input swmm_pkg::data_t s, input logic l,
                                        output swmm_pkg::data_t lo,
                                        output swmm_pkg::data_t hi);
        int unsigned n;
        bit          due;
        n = effective_len();
        // expiry by modular age, so a wrapped position still ages right
        while (lo_deque.size() > 0 && (sample_pos - lo_deque[0].pos) >= n)
        begin
            void'(lo_deque.pop_front());
        end
        while (hi_deque.size() > 0 && (sample_pos - hi_deque[0].pos) >= n)
        begin
            void'(hi_deque.pop_front());
        end
        // equal tail values are dominated on both sides
        while (lo_deque.size() > 0 && lo_deque[$].value >= s)
        begin
            void'(lo_deque.pop_back());
        end
        while (hi_deque.size() > 0 && hi_deque[$].value <= s)
        begin
            void'(hi_deque.pop_back());
        end
        if (lo_deque.size() < swmm_pkg::WINDOW_MAX)
        begin
            lo_deque.push_back('{s, sample_pos});
        end
        if (hi_deque.size() < swmm_pkg::WINDOW_MAX)
        begin
            hi_deque.push_back('{s, sample_pos});
        end
        lo = lo_deque[0].value;
        hi = hi_deque[0].value;
        // full flag is sticky for the rest of the sequence
        due = win_full || ((64'(sample_pos) + 64'd1) >= 64'(n));
        if (due)
        begin
            win_full = 1'b1;
        end
        sample_pos = sample_pos + 32'd1;
        if (l)
        begin
            clear_windows();
        end
        return due;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        err_count++;
    endtask

    // result side: compare each accepted word, then pick next ready level
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (pending_windows.size() == 0)
                begin
                    report_mismatch($sformatf("word min=%0d max=%0d with none pending",
                                              results.window_min, results.window_max));
                end
                else
                begin
                    arrived_want = pending_windows.pop_front();
                    if (results.window_min !== arrived_want.lo)
                    begin
                        report_mismatch($sformatf("window_min got %0d want %0d",
                                                  results.window_min, arrived_want.lo));
                    end
                    if (results.window_max !== arrived_want.hi)
                    begin
                        report_mismatch($sformatf("window_max got %0d want %0d",
                                                  results.window_max, arrived_want.hi));
                    end
                end
            end
            results.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // hang detection: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready) ||
            (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // valid stays high from one word to the next unless a gap is drawn
    task automatic send_sample(input swmm_pkg::data_t s, input logic l, input bit typed,
                               input swmm_pkg::data_t t_lo, input swmm_pkg::data_t t_hi);
        swmm_pkg::data_t p_lo;
        swmm_pkg::data_t p_hi;
        bit              due;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid   <= 1'b1;
        samples.sample  <= s;
        samples.last_in <= l;
        do
        begin
            @(posedge clk);
        end
        while (!samples.ready);
        due = slide_window(s, l, p_lo, p_hi);
        if (typed)
        begin
            pending_windows.push_back('{t_lo, t_hi});
        end
        else if (due)
        begin
            pending_windows.push_back('{p_lo, p_hi});
        end
        samples_sent++;
    endtask

    // block is idle: every word back, plus a SETTLE_CYCLES wait for samples that
    // produced no word and may still be in the deque update
    task automatic settle();
        samples.valid <= 1'b0;
        while (pending_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input swmm_pkg::len_t v);
        settle();
        cfg.valid      <= 1'b1;
        cfg.window_len <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.valid   <= 1'b0;
        win_len_reg = v;
    endtask

    // ------------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------------
    function automatic swmm_pkg::data_t next_value(input shape_e sh);
        case (sh)
            SHAPE_NARROW:
            begin
                // many ties, exercises the equal-value pops
                return swmm_pkg::data_t'($urandom_range(0, 8)) - swmm_pkg::data_t'(4);
            end
            SHAPE_RISE:
            begin
                ramp_val = ramp_val + swmm_pkg::data_t'($urandom_range(1, 3));
                return ramp_val;
            end
            SHAPE_FALL:
            begin
                ramp_val = ramp_val - swmm_pkg::data_t'($urandom_range(1, 3));
                return ramp_val;
            end
            SHAPE_EDGES:
            begin
                case ($urandom_range(0, 5))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return SAMPLE_ZERO;
                    3: return SAMPLE_NEG1;
                    4: return SAMPLE_MIN + swmm_pkg::data_t'(1);
                    default: return SAMPLE_MAX - swmm_pkg::data_t'(1);
                endcase
            end
            default:
            begin
                return swmm_pkg::data_t'($urandom);
            end
        endcase
    endfunction

    // mostly short windows so that words come often; a few saturated lengths
    function automatic swmm_pkg::len_t pick_window();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return LEN_ZERO;
        end
        if (r < 12)
        begin
            return swmm_pkg::LEN_ONE;
        end
        if (r < 68)
        begin
            return swmm_pkg::len_t'($urandom_range(2, 16));
        end
        if (r < 92)
        begin
            return swmm_pkg::len_t'($urandom_range(17, 64));
        end
        if (r < 97)
        begin
            return swmm_pkg::len_t'($urandom_range(65, 160));
        end
        return swmm_pkg::len_t'($urandom_range(swmm_pkg::WINDOW_MAX + 1, 2047));
    endfunction

    // one sequence closed by last_in; shape may change and the window may
    // be rewritten partway through
    task automatic run_sequence();
        int unsigned eff;
        int unsigned seq_len;
        shape_e      sh;
        eff = effective_len();
        // long windows only get short sequences: they show the no-word case
        seq_len  = (eff > 200) ? $urandom_range(1, 40) : $urandom_range(1, 3 * eff + 8);
        sh       = shape_e'($urandom_range(0, 4));
        ramp_val = swmm_pkg::data_t'($urandom);
        for (int k = 0; k < seq_len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                sh = shape_e'($urandom_range(0, 4));
            end
            if (k > 0 && $urandom_range(0, 29) == 0)
            begin
                set_window(pick_window());
            end
            send_sample(next_value(sh), (k == seq_len - 1), 1'b0, SAMPLE_ZERO, SAMPLE_ZERO);
        end
    endtask

    task automatic send_run(input shape_e sh, input int n, input bit close);
        for (int k = 0; k < n; k++)
        begin
            send_sample(next_value(sh), close && (k == n - 1), 1'b0, SAMPLE_ZERO,
                        SAMPLE_ZERO);
        end
    endtask

    // full-depth window: a strictly rising stretch fills the min deque to
    // capacity, then the window is cut mid-sequence so the expiry has to
    // drain it, then put back to the exact depth while words keep flowing
    task automatic long_sequence();
        set_window(LEN_RAW_TOP);
        send_run(SHAPE_WIDE, 40, 1'b0);
        ramp_val = SAMPLE_MIN + swmm_pkg::data_t'($urandom_range(0, 1000));
        send_run(SHAPE_RISE, 1040, 1'b0);
        set_window(swmm_pkg::len_t'(5));
        send_run(SHAPE_WIDE, 30, 1'b0);
        set_window(swmm_pkg::LEN_MAX);
        ramp_val = swmm_pkg::data_t'($urandom_range(0, 1000));
        send_run(SHAPE_FALL, 30, 1'b0);
        send_run(SHAPE_EDGES, 10, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        samples.valid   <= 1'b0;
        samples.sample  <= '0;
        samples.last_in <= 1'b0;
        cfg.valid       <= 1'b0;
        cfg.window_len  <= '0;
        err_count    = 0;
        samples_sent = 0;
        quiet_cycles = 0;
        ramp_val     = '0;
        win_len_reg  = swmm_pkg::LEN_ONE;
        clear_windows();

        // first regime: sender idles now and then, receiver mostly stalls
        src_idle_pct = 24;
        snk_idle_pct = 85;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                set_window(swmm_pkg::len_t'(directed_plan[i].word));
            end
            else
            begin
                send_sample(swmm_pkg::data_t'(directed_plan[i].word),
                            directed_plan[i].last, directed_plan[i].typed,
                            directed_plan[i].lo, directed_plan[i].hi);
            end
        end

        // random sequences over short windows, two idling regimes
        for (int regime = 0; regime < 2; regime++)
        begin
            if (regime == 1)
            begin
                settle();
                src_idle_pct = 85;
                snk_idle_pct = 24;
            end
            for (int target = samples_sent + REGIME_ITEMS; samples_sent < target; )
            begin
                set_window(pick_window());
                run_sequence();
                if ($urandom_range(0, 1) == 0)
                begin
                    run_sequence();
                end
            end
        end

        // no idling on either side for the full-depth sequence
        settle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        long_sequence();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_ifs.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_deque.sv
hw/rtl/sliding_window_min_max.sv
test/tb_sliding_window_min_max.sv
